// ===== rtl/assert_macros.svh =====
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define BOR_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// sequence or expression must never be seen outside reset
`define BOR_ASSERT_NEVER(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) not (prop)) \
    else $error("forbidden condition seen");

`endif

// ===== rtl/bor_pkg.sv =====
// shared constants, command and status types for the belady replacement cache
package bor_pkg;

  localparam int unsigned CapacityDef = 16;
  localparam int unsigned CfgW        = 5;
  localparam int unsigned ObjW        = 64;
  localparam int unsigned TimeW       = 32;
  localparam int unsigned CntW        = 32;

  localparam logic [CfgW-1:0] CfgReset = 5'd16;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_COMMIT
  } state_e;

  typedef struct packed {
    logic load;
    logic scan;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic last_addr;
  } status_t;

endpackage

// ===== rtl/bor_ctrl.sv =====
// controller state machine sequencing load, tag scan, drain and commit
module bor_ctrl import bor_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    start_i,
  input  status_t status_i,
  output cmd_t    cmd_o,
  output logic    busy_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    busy_o  = 1'b1;
    case (state_q)
      ST_IDLE: begin
        busy_o = 1'b0;
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd_o.scan = 1'b1;
        if (status_i.last_addr) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_d = ST_COMMIT;
      end
      ST_COMMIT: begin
        cmd_o.commit = 1'b1;
        state_d      = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/bor_dp.sv =====
// datapath: entry memories, valid bits, scan registers, update and result registers
module bor_dp import bor_pkg::*; #(
  parameter int unsigned Capacity = CapacityDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cmd_t             cmd_i,
  output status_t          status_o,
  input  logic             cfg_we_i,
  input  logic [CfgW-1:0]  cfg_wdata_i,
  input  logic [ObjW-1:0]  object_id_i,
  input  logic [TimeW-1:0] next_use_time_i,
  output logic             done_o,
  output logic             hit_o,
  output logic             bypassed_o,
  output logic             evicted_o,
  output logic [ObjW-1:0]  evicted_id_o,
  output logic [CntW-1:0]  miss_total_o
);

  localparam int unsigned IdxW = (Capacity > 1) ? $clog2(Capacity) : 1;
  localparam int unsigned OccW = $clog2(Capacity + 1);
  localparam int unsigned CmpW = (OccW > CfgW) ? OccW : CfgW;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(Capacity - 1);
  localparam logic [CmpW-1:0] CapMax  = CmpW'(Capacity);

  logic [ObjW-1:0]  obj_mem [Capacity];
  logic [TimeW-1:0] nu_mem  [Capacity];

  logic [CfgW-1:0]     cfg_q;
  logic [ObjW-1:0]     obj_q;
  logic [TimeW-1:0]    nu_q;
  logic [IdxW-1:0]     addr_q;
  logic [IdxW-1:0]     proc_idx_q;
  logic                proc_v_q;
  logic [ObjW-1:0]     obj_rd_q;
  logic [TimeW-1:0]    nu_rd_q;
  logic                match_found_q, far_found_q, free_found_q;
  logic [IdxW-1:0]     match_idx_q, far_idx_q, free_idx_q;
  logic [TimeW-1:0]    far_time_q;
  logic [ObjW-1:0]     far_obj_q;
  logic [Capacity-1:0] valid_q;
  logic [OccW-1:0]     occ_q;
  logic [CntW-1:0]     miss_q;

  logic            ent_valid, tag_eq, farther;
  logic [CmpW-1:0] cfg_ext, eff_cap, occ_ext;
  logic            full, evict_ok, do_insert, do_evict, do_bypass, wr_en;
  logic [IdxW-1:0] wr_addr;

  assign status_o.last_addr = (addr_q == LastIdx);

  // scan comparisons on the registered read data
  assign ent_valid = valid_q[proc_idx_q];
  assign tag_eq    = (obj_rd_q == obj_q);
  assign farther   = !far_found_q || (nu_rd_q > far_time_q);

  // update decision
  assign cfg_ext   = CmpW'(cfg_q);
  assign occ_ext   = CmpW'(occ_q);
  always_comb begin
    if (cfg_ext == '0) begin
      eff_cap = CmpW'(1);
    end else if (cfg_ext > CapMax) begin
      eff_cap = CapMax;
    end else begin
      eff_cap = cfg_ext;
    end
  end
  assign full      = (occ_ext >= eff_cap) || !free_found_q;
  assign evict_ok  = far_found_q && (far_time_q >= nu_q);
  assign do_insert = !match_found_q && !full;
  assign do_evict  = !match_found_q && full && evict_ok;
  assign do_bypass = !match_found_q && full && !evict_ok;
  assign wr_en     = cmd_i.commit && (match_found_q || do_insert || do_evict);

  always_comb begin
    if (match_found_q) begin
      wr_addr = match_idx_q;
    end else if (full) begin
      wr_addr = far_idx_q;
    end else begin
      wr_addr = free_idx_q;
    end
  end

  // entry memories, one read and one write port
  always_ff @(posedge clk_i) begin
    obj_rd_q <= obj_mem[addr_q];
    nu_rd_q  <= nu_mem[addr_q];
    if (wr_en) begin
      obj_mem[wr_addr] <= obj_q;
      nu_mem[wr_addr]  <= nu_q;
    end
  end

  // request and scan payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      obj_q <= object_id_i;
      nu_q  <= next_use_time_i;
    end
    proc_idx_q <= addr_q;
    if (proc_v_q && ent_valid) begin
      if (!match_found_q && tag_eq) begin
        match_idx_q <= proc_idx_q;
      end
      if (farther) begin
        far_idx_q  <= proc_idx_q;
        far_time_q <= nu_rd_q;
        far_obj_q  <= obj_rd_q;
      end
    end
    if (proc_v_q && !ent_valid && !free_found_q) begin
      free_idx_q <= proc_idx_q;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q         <= CfgReset;
      addr_q        <= '0;
      proc_v_q      <= 1'b0;
      match_found_q <= 1'b0;
      far_found_q   <= 1'b0;
      free_found_q  <= 1'b0;
      valid_q       <= '0;
      occ_q         <= '0;
      miss_q        <= '0;
      done_o        <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        cfg_q <= cfg_wdata_i;
      end
      done_o   <= cmd_i.commit;
      proc_v_q <= cmd_i.scan;
      if (cmd_i.load) begin
        addr_q        <= '0;
        match_found_q <= 1'b0;
        far_found_q   <= 1'b0;
        free_found_q  <= 1'b0;
      end else begin
        if (cmd_i.scan) begin
          addr_q <= status_o.last_addr ? '0 : addr_q + IdxW'(1);
        end
        if (proc_v_q && ent_valid) begin
          if (tag_eq) begin
            match_found_q <= 1'b1;
          end
          far_found_q <= 1'b1;
        end
        if (proc_v_q && !ent_valid) begin
          free_found_q <= 1'b1;
        end
      end
      if (cmd_i.commit) begin
        if (!match_found_q && (miss_q != '1)) begin
          miss_q <= miss_q + CntW'(1);
        end
        if (do_insert) begin
          valid_q[free_idx_q] <= 1'b1;
          occ_q               <= occ_q + OccW'(1);
        end
      end
    end
  end

  // result registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      hit_o        <= match_found_q;
      bypassed_o   <= do_bypass;
      evicted_o    <= do_evict;
      evicted_id_o <= do_evict ? far_obj_q : '0;
    end
  end

  assign miss_total_o = miss_q;

endmodule

// ===== rtl/belady_optimal_replacement.sv =====
// top level of the fully associative cache with optimal replacement and bypass
//
// channel  | handshake                | payload
// ---------+--------------------------+------------------------------------------
// request  | start, busy              | object_id_i, next_use_time_i
// result   | done_o (one-cycle strobe)| hit_o, bypassed_o, evicted_o,
//          |                          | evicted_id_o, miss_total_o
// config   | cfg_we_i                 | cfg_wdata_i (capacity in use)
//
// a request is transferred when start is high and busy low; busy then stays high
// through one memory read per entry, the drain of the read register and the
// update, so the block takes no new request before it is through with the last.
// done_o rises in the cycle after the update and busy is low in that cycle.
// no clearing pass after reset: valid bits are cleared at once.
// the result receiver cannot stall, so results are never held.
module belady_optimal_replacement import bor_pkg::*; #(
  parameter int unsigned Capacity = CapacityDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  logic [ObjW-1:0]  object_id_i,
  input  logic [TimeW-1:0] next_use_time_i,
  input  logic             cfg_we_i,
  input  logic [CfgW-1:0]  cfg_wdata_i,
  output logic             done_o,
  output logic             hit_o,
  output logic             bypassed_o,
  output logic             evicted_o,
  output logic [ObjW-1:0]  evicted_id_o,
  output logic [CntW-1:0]  miss_total_o
);

  cmd_t    cmd;
  status_t status;

  bor_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .status_i (status),
    .cmd_o    (cmd),
    .busy_o   (busy)
  );

  bor_dp #(
    .Capacity (Capacity)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .object_id_i     (object_id_i),
    .next_use_time_i (next_use_time_i),
    .done_o          (done_o),
    .hit_o           (hit_o),
    .bypassed_o      (bypassed_o),
    .evicted_o       (evicted_o),
    .evicted_id_o    (evicted_id_o),
    .miss_total_o    (miss_total_o)
  );

endmodule

// ===== rtl/bor_checker.sv =====
// port-level checker for the replacement cache and its bind
`include "assert_macros.svh"

module bor_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start,
  input logic        busy,
  input logic        done_o,
  input logic        hit_o,
  input logic        bypassed_o,
  input logic        evicted_o,
  input logic [63:0] evicted_id_o,
  input logic [31:0] miss_total_o
);

  // an accepted request keeps the block busy
  `BOR_ASSERT(a_accept_busy, clk_i, rst_ni, (start && !busy) |=> busy)

  // the block only goes idle by delivering a result
  `BOR_ASSERT(a_fell_done, clk_i, rst_ni, $fell(busy) |-> done_o)

  // at most one outcome per transfer
  `BOR_ASSERT(a_outcome, clk_i, rst_ni,
    done_o |-> $onehot0({hit_o, bypassed_o, evicted_o}))

  // no evicted id without an eviction
  `BOR_ASSERT_NEVER(a_evid, clk_i, rst_ni,
    done_o && !evicted_o && (evicted_id_o != 64'd0))

  // a hit leaves the miss count alone
  `BOR_ASSERT(a_hit_count, clk_i, rst_ni, (done_o && hit_o) |-> $stable(miss_total_o))

endmodule

bind belady_optimal_replacement bor_checker u_checker (.*);
